// ----- design/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared constants, codes and types for the page-table translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int TLB_DEPTH   = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 32;
    localparam int TLB_IDX_W = $clog2(TLB_DEPTH);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);

    typedef enum logic [1:0] {
        ST_TLB_HIT        = 2'd0,
        ST_TABLE_HIT      = 2'd1,
        ST_FAULT_LOADED   = 2'd2,
        ST_FAULT_NO_FRAME = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the address of a new transfer
        logic lookup;   // TLB search and page-table read
        logic resolve;  // pick frame, update tables and counters
    } ctrl_cmd_t;

endpackage

// ----- design/tpt_ram.sv -----
// ----------------------------------------------------------------------------
// tpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: idle, lookup, resolve; raises the done strobe after resolve.
// ----------------------------------------------------------------------------
module tpt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output tpt_pkg::ctrl_cmd_t cmd
);

    tpt_pkg::state_t state_reg;
    tpt_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpt_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = tpt_pkg::S_LOOKUP;
                end
            end
            tpt_pkg::S_LOOKUP:  state_next = tpt_pkg::S_RESOLVE;
            tpt_pkg::S_RESOLVE: state_next = tpt_pkg::S_IDLE;
            default:            state_next = tpt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done_next = 1'b0;
        unique case (state_reg)
            tpt_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            tpt_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            tpt_pkg::S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                done_next   = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ----- design/tpt_datapath.sv -----
// ----------------------------------------------------------------------------
// tpt_datapath
// TLB registers, page-table store, frame allocator, counters, result registers.
// ----------------------------------------------------------------------------
module tpt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpt_pkg::ctrl_cmd_t            cmd,
    input  logic [tpt_pkg::ADDR_W-1:0]    logical_address,
    output logic [tpt_pkg::ADDR_W-1:0]    physical_address,
    output logic [1:0]                    status,
    output logic [tpt_pkg::PAGE_W-1:0]    page_number,
    output logic [tpt_pkg::FRAME_W-1:0]   frame_number,
    output logic [tpt_pkg::CNT_W-1:0]     translation_count,
    output logic [tpt_pkg::CNT_W-1:0]     tlb_hit_count,
    output logic [tpt_pkg::CNT_W-1:0]     fault_count
);

    localparam int TD = tpt_pkg::TLB_DEPTH;
    localparam int AW = tpt_pkg::ADDR_W;
    localparam int PW = tpt_pkg::PAGE_W;
    localparam int FW = tpt_pkg::FRAME_W;
    localparam int IW = tpt_pkg::TLB_IDX_W;
    localparam int CW = tpt_pkg::CNT_W;
    localparam int OB = tpt_pkg::OFFSET_BITS;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == '1) ? v : v + CW'(1);
    endfunction

    // address capture
    logic [AW-1:0] addr_reg;
    logic [PW-1:0] page;
    logic [OB-1:0] offset;

    assign page   = PW'(addr_reg >> OB);
    assign offset = addr_reg[OB-1:0];

    // TLB
    logic [PW-1:0] tlb_page_reg  [TD];
    logic [FW-1:0] tlb_frame_reg [TD];
    logic [TD-1:0] tlb_valid_reg;
    logic [IW-1:0] tlb_wp_reg;

    // page table valid bits and allocator
    logic [tpt_pkg::PAGE_COUNT-1:0] table_valid_reg;
    logic [FW-1:0]                  next_free_reg;
    logic                           exhausted_reg;

    // lookup results
    logic          hit_reg;
    logic [FW-1:0] hit_frame_reg;
    logic          tv_reg;
    logic [FW-1:0] table_rdata;

    // counters
    logic [CW-1:0] trans_cnt_reg;
    logic [CW-1:0] hit_cnt_reg;
    logic [CW-1:0] fault_cnt_reg;

    // result registers
    logic [AW-1:0]    phys_reg;
    tpt_pkg::status_t status_reg;
    logic [PW-1:0]    page_reg;
    logic [FW-1:0]    frame_reg;

    // parallel TLB compare, lowest matching index wins
    logic          hit_c;
    logic [FW-1:0] hit_frame_c;

    always_comb
    begin
        hit_c       = 1'b0;
        hit_frame_c = '0;
        for (int i = TD - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page))
            begin
                hit_c       = 1'b1;
                hit_frame_c = tlb_frame_reg[i];
            end
        end
    end

    // resolve decision
    tpt_pkg::status_t st_c;
    logic [FW-1:0]    frame_c;
    logic             tlb_ins_c;
    logic             table_wr_c;

    always_comb
    begin
        tlb_ins_c  = 1'b0;
        table_wr_c = 1'b0;
        if (hit_reg)
        begin
            st_c    = tpt_pkg::ST_TLB_HIT;
            frame_c = hit_frame_reg;
        end
        else if (tv_reg)
        begin
            st_c      = tpt_pkg::ST_TABLE_HIT;
            frame_c   = table_rdata;
            tlb_ins_c = 1'b1;
        end
        else if (exhausted_reg)
        begin
            st_c    = tpt_pkg::ST_FAULT_NO_FRAME;
            frame_c = '0;
        end
        else
        begin
            st_c       = tpt_pkg::ST_FAULT_LOADED;
            frame_c    = next_free_reg;
            tlb_ins_c  = 1'b1;
            table_wr_c = 1'b1;
        end
    end

    tpt_ram #(
        .WIDTH (FW),
        .DEPTH (tpt_pkg::PAGE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (cmd.resolve && table_wr_c),
        .waddr (page),
        .wdata (next_free_reg),
        .re    (cmd.lookup),
        .raddr (page),
        .rdata (table_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= logical_address;
        end
        if (cmd.lookup)
        begin
            hit_reg       <= hit_c;
            hit_frame_reg <= hit_frame_c;
            tv_reg        <= table_valid_reg[page];
        end
        if (cmd.resolve)
        begin
            if (tlb_ins_c)
            begin
                tlb_page_reg[tlb_wp_reg]  <= page;
                tlb_frame_reg[tlb_wp_reg] <= frame_c;
            end
            status_reg <= st_c;
            page_reg   <= page;
            frame_reg  <= frame_c;
            phys_reg   <= (st_c == tpt_pkg::ST_FAULT_NO_FRAME) ? '0 : AW'({frame_c, offset});
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg   <= '0;
            tlb_wp_reg      <= '0;
            table_valid_reg <= '0;
            next_free_reg   <= '0;
            exhausted_reg   <= 1'b0;
            trans_cnt_reg   <= '0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
        end
        else if (cmd.resolve)
        begin
            trans_cnt_reg <= sat_inc(trans_cnt_reg);
            if (hit_reg)
            begin
                hit_cnt_reg <= sat_inc(hit_cnt_reg);
            end
            if (!hit_reg && !tv_reg)
            begin
                fault_cnt_reg <= sat_inc(fault_cnt_reg);
            end
            if (tlb_ins_c)
            begin
                tlb_valid_reg[tlb_wp_reg] <= 1'b1;
                tlb_wp_reg <= (tlb_wp_reg == IW'(TD - 1)) ? '0 : tlb_wp_reg + IW'(1);
            end
            if (table_wr_c)
            begin
                table_valid_reg[page] <= 1'b1;
                if (next_free_reg == FW'(tpt_pkg::FRAME_COUNT - 1))
                begin
                    exhausted_reg <= 1'b1;
                end
                else
                begin
                    next_free_reg <= next_free_reg + FW'(1);
                end
            end
        end
    end

    assign physical_address  = phys_reg;
    assign status            = status_reg;
    assign page_number       = page_reg;
    assign frame_number      = frame_reg;
    assign translation_count = trans_cnt_reg;
    assign tlb_hit_count     = hit_cnt_reg;
    assign fault_count       = fault_cnt_reg;

endmodule

// ----- design/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Demand-paging address translator with a 16-entry FIFO-replaced TLB.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  request  | start / busy          | logical_address
//  result   | done (1-cycle strobe) | physical_address, status, page_number,
//           |                       | frame_number, translation_count,
//           |                       | tlb_hit_count, fault_count
//
//  A request transfer happens on a clock edge with start high and busy low.
//  Each transfer runs a TLB search plus page-table RAM read
//  (registered RAM output), then a resolve cycle that updates TLB, page
//  table, allocator and counters; done pulses in the cycle after resolve,
//  and busy is already low then, so a new start is taken in that cycle.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  The receiver cannot stall: results stay on the ports until the resolve
//  cycle of the next transfer.
//
module tlb_page_table_translator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] logical_address,
    output logic        done,
    output logic [15:0] physical_address,
    output logic [1:0]  status,
    output logic [7:0]  page_number,
    output logic [7:0]  frame_number,
    output logic [31:0] translation_count,
    output logic [31:0] tlb_hit_count,
    output logic [31:0] fault_count
);

    tpt_pkg::ctrl_cmd_t cmd;

    // sequencer
    tpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // TLB, page table, allocator and statistics
    tpt_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .logical_address   (logical_address),
        .physical_address  (physical_address),
        .status            (status),
        .page_number       (page_number),
        .frame_number      (frame_number),
        .translation_count (translation_count),
        .tlb_hit_count     (tlb_hit_count),
        .fault_count       (fault_count)
    );

    // result strobe only when the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // an accepted transfer keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("transfer accepted but not busy");

    // no-frame faults report zero address and frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == tpt_pkg::ST_FAULT_NO_FRAME))
            |-> (physical_address == 16'd0 && frame_number == 8'd0))
        else $error("no_frame result not zeroed");

    // mapped results carry the frame in the upper address bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != tpt_pkg::ST_FAULT_NO_FRAME))
            |-> (physical_address[15:8] == frame_number && translation_count != 32'd0))
        else $error("frame and physical address disagree");

endmodule
